@@ design/cbs_pkg.sv @@
// Shared types and constants of the color blindness simulation pixel unit.
`default_nettype none

package cbs_pkg;

	// Kind of dichromacy that is simulated.
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_PROT = 2'd1,
		MODE_DEUT = 2'd2,
		MODE_TRIT = 2'd3
	} mode_t;

	// Register indexes, taken from paddr[2].
	localparam logic REG_MODE     = 1'b0;
	localparam logic REG_SEVERITY = 1'b1;

	// Full dichromacy in unsigned Q12.
	localparam logic [12:0] SEV_ONE = 13'd4096;

endpackage

`default_nettype wire

@@ design/color_blindness_simulation_pixel_unit.sv @@
// Top level of the color blindness simulation pixel unit: a six-stage pixel pipeline.
`default_nettype none

// Channel   Direction  Beat contents
// s_axis    in         one RGB pixel, 8 bits per component
// m_axis    out        one simulated RGB pixel, 8 bits per component
// apb       in/out     deficiency_mode at 0x0, severity at 0x4
//
// A pixel accepted at the input enters stage 1 and moves through stages 2 to 6 in order; the
// stage 6 register drives the output beat. One pixel can enter in every cycle while a stage is
// empty or the output beat is taken. The depth is set by the three matrix products, each split
// into a multiply stage and an add-and-round stage. Reset clears the valid bits of all stages
// and returns the registers to mode none and full severity. A stall on the output holds the last
// stage; earlier stages keep moving into empty slots, so bubbles are squeezed out and no
// beat is lost or repeated. Dichromacy coefficients follow a register write in the next cycle.
module color_blindness_simulation_pixel_unit #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Pixel input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
	// Pixel output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
	// Register port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import cbs_pkg::*;

	localparam int F = COEF_FRAC_BITS;
	localparam int LMS_FRAC = 8;
	localparam longint ONE = 64'sd1 <<< F;

	// RGB to LMS coefficients, all positive, rounded to nearest.
	localparam longint TO_LMS [3][3] = '{
		'{(178824 * ONE + 5000) / 10000, (435161 * ONE + 5000) / 10000,
		  (411935 * ONE + 50000) / 100000},
		'{(345565 * ONE + 50000) / 100000, (271554 * ONE + 5000) / 10000,
		  (386714 * ONE + 50000) / 100000},
		'{(299566 * ONE + 5000000) / 10000000, (184309 * ONE + 500000) / 1000000,
		  (146709 * ONE + 50000) / 100000}
	};

	// LMS to RGB coefficients; negative ones are rounded by magnitude, halves away from zero.
	localparam longint TO_RGB [3][3] = '{
		'{(809 * ONE + 5000) / 10000, -((1305 * ONE + 5000) / 10000),
		  (1167 * ONE + 5000) / 10000},
		'{-((102 * ONE + 5000) / 10000), (540 * ONE + 5000) / 10000,
		  -((1136 * ONE + 5000) / 10000)},
		'{-((4 * ONE + 5000) / 10000), -((41 * ONE + 5000) / 10000),
		  (6935 * ONE + 5000) / 10000}
	};

	// Off-diagonal dichromacy coefficients at full severity.
	localparam longint PROT_M = (202344 * ONE + 50000) / 100000;
	localparam longint PROT_S = -((252581 * ONE + 50000) / 100000);
	localparam longint DEUT_L = (494207 * ONE + 500000) / 1000000;
	localparam longint DEUT_S = (124827 * ONE + 50000) / 100000;
	localparam longint TRIT_L = -((395913 * ONE + 500000) / 1000000);
	localparam longint TRIT_M = (801109 * ONE + 500000) / 1000000;

	// Datapath widths.
	localparam int LP_W  = F + 14;          // one RGB to LMS product
	localparam int LA_W  = F + 15;          // sum of three of them
	localparam int LMS_W = 24;              // LMS in signed Q8
	localparam int DK_W  = F + 3;           // dichromacy coefficient
	localparam int DP_W  = DK_W + LMS_W;    // dichromacy product
	localparam int DS_W  = DP_W + 2;
	localparam int SIM_W = 27;              // simulated LMS in signed Q8
	localparam int CR_W  = F + 1;           // LMS to RGB coefficient
	localparam int RP_W  = CR_W + SIM_W;
	localparam int RS_W  = RP_W + 2;

	localparam longint LMS_HALF = 64'sd1 <<< (F - LMS_FRAC - 1);
	localparam longint DM_HALF  = 64'sd1 <<< (F - 1);
	localparam longint RGB_HALF = 64'sd1 <<< (F + LMS_FRAC - 1);

	// ------------------------------------------------------------------
	// Registers.
	// ------------------------------------------------------------------
	mode_t       mode_q;
	logic [12:0] sev_raw_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NONE;
			sev_raw_q <= SEV_ONE;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE:     mode_q    <= mode_t'(pwdata[1:0]);
				REG_SEVERITY: sev_raw_q <= pwdata[12:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MODE:     prdata = {30'd0, mode_q};
			REG_SEVERITY: prdata = {19'd0, sev_raw_q};
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Dichromacy row, rebuilt from the registers every cycle. Only one row of
	// the matrix differs from identity, so three coefficients describe it.
	// ------------------------------------------------------------------
	function automatic logic signed [DK_W-1:0] scale_coef(
		input logic signed [DK_W-1:0] cq,
		input logic [12:0]            sv
	);
		logic signed [DK_W+13:0] p;
		p = (DK_W + 14)'(cq) * $signed({1'b0, sv});
		return DK_W'((p + (DK_W + 14)'(2048)) >>> 12);
	endfunction

	logic [12:0]             sev;
	logic [F+13:0]           keep_t;
	logic signed [DK_W-1:0]  keep_c, ca, cb, sa, sb;
	logic signed [DK_W-1:0]  dk_c [3];
	logic signed [DK_W-1:0]  dk_q [3];

	always_comb begin
		// Severity above full counts as full.
		sev    = (sev_raw_q > SEV_ONE) ? SEV_ONE : sev_raw_q;
		keep_t = ((F + 14)'(sev) << F) + (F + 14)'(2048);
		keep_c = DK_W'(ONE) - DK_W'(keep_t >> 12);
		unique case (mode_q)
			MODE_PROT: begin
				ca = DK_W'(PROT_M);
				cb = DK_W'(PROT_S);
			end
			MODE_DEUT: begin
				ca = DK_W'(DEUT_L);
				cb = DK_W'(DEUT_S);
			end
			MODE_TRIT: begin
				ca = DK_W'(TRIT_L);
				cb = DK_W'(TRIT_M);
			end
			default: begin
				ca = '0;
				cb = '0;
			end
		endcase
		sa = scale_coef(ca, sev);
		sb = scale_coef(cb, sev);
		unique case (mode_q)
			MODE_PROT: dk_c = '{keep_c, sa, sb};
			MODE_DEUT: dk_c = '{sa, keep_c, sb};
			MODE_TRIT: dk_c = '{sa, sb, keep_c};
			default:   dk_c = '{DK_W'(ONE), '0, '0};
		endcase
	end

	always_ff @(posedge clk) begin
		dk_q <= dk_c;
	end

	// ------------------------------------------------------------------
	// Flow control. A stage moves when it is empty or when the stage after it
	// moves; the last stage moves when the output beat is taken or absent.
	// ------------------------------------------------------------------
	logic [6:1] adv;
	logic       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv[6]   = !v_s6 || m_tready;
	assign adv[5]   = !v_s5 || adv[6];
	assign adv[4]   = !v_s4 || adv[5];
	assign adv[3]   = !v_s3 || adv[4];
	assign adv[2]   = !v_s2 || adv[3];
	assign adv[1]   = !v_s1 || adv[2];
	assign s_tready = adv[1];
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv[1]) v_s1 <= s_tvalid;
			if (adv[2]) v_s2 <= v_s1;
			if (adv[3]) v_s3 <= v_s2;
			if (adv[4]) v_s4 <= v_s3;
			if (adv[5]) v_s5 <= v_s4;
			if (adv[6]) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: RGB to LMS products.
	// ------------------------------------------------------------------
	logic [7:0]      rgb [3];
	logic [LP_W-1:0] lp_s1 [3][3];

	assign rgb[0] = s_tdata[7:0];
	assign rgb[1] = s_tdata[15:8];
	assign rgb[2] = s_tdata[23:16];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					lp_s1[i][j] <= LP_W'(TO_LMS[i][j]) * LP_W'(rgb[j]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: sum and round to Q8 LMS. The products are never negative.
	// ------------------------------------------------------------------
	logic [LA_W-1:0]         lsum [3];
	logic signed [LMS_W-1:0] lms_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = LA_W'(lp_s1[i][0]) + LA_W'(lp_s1[i][1]) + LA_W'(lp_s1[i][2])
			        + LA_W'(LMS_HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				lms_s2[i] <= LMS_W'(lsum[i] >> (F - LMS_FRAC));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: products of the dichromacy row; LMS travels alongside.
	// ------------------------------------------------------------------
	logic signed [DP_W-1:0]  dp_s3 [3];
	logic signed [LMS_W-1:0] lms_s3 [3];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int j = 0; j < 3; j++) begin
				dp_s3[j]  <= DP_W'(lms_s2[j]) * DP_W'(dk_q[j]);
				lms_s3[j] <= lms_s2[j];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: the changed row is summed and rounded back to Q8; the other
	// rows are identity rows and pass LMS through unchanged.
	// ------------------------------------------------------------------
	logic signed [DS_W-1:0]  dsum;
	logic signed [SIM_W-1:0] drow;
	logic signed [SIM_W-1:0] sim_s4 [3];
	logic [1:0]              row;

	always_comb begin
		dsum = DS_W'(dp_s3[0]) + DS_W'(dp_s3[1]) + DS_W'(dp_s3[2]) + DS_W'(DM_HALF);
		drow = SIM_W'(dsum >>> F);
		row  = 2'(mode_q) - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int i = 0; i < 3; i++) begin
				if (mode_q != MODE_NONE && row == 2'(i)) begin
					sim_s4[i] <= drow;
				end else begin
					sim_s4[i] <= SIM_W'(lms_s3[i]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: LMS to RGB products.
	// ------------------------------------------------------------------
	logic signed [RP_W-1:0] rp_s5 [3][3];

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					rp_s5[i][j] <= RP_W'(sim_s4[j]) * RP_W'(TO_RGB[i][j]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: sum, round to an integer, saturate to a pixel code. This is
	// the output register.
	// ------------------------------------------------------------------
	logic signed [RS_W-1:0] rsum [3];
	logic signed [RS_W-1:0] rint [3];
	logic [7:0]             pix [3];
	logic [23:0]            tdata_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = RS_W'(rp_s5[i][0]) + RS_W'(rp_s5[i][1]) + RS_W'(rp_s5[i][2])
			        + RS_W'(RGB_HALF);
			rint[i] = rsum[i] >>> (F + LMS_FRAC);
			if (rint[i] < 0) begin
				pix[i] = 8'd0;
			end else if (rint[i] > 255) begin
				pix[i] = 8'd255;
			end else begin
				pix[i] = rint[i][7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			tdata_s6 <= {pix[2], pix[1], pix[0]};
		end
	end

	assign m_tdata = tdata_s6;

endmodule

`default_nettype wire

@@ design/color_blindness_simulation_pixel_unit_checker.sv @@
// Port-level checker of the color blindness simulation pixel unit and its bind.
`default_nettype none

module cbs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);

	import cbs_pkg::*;

	// A stalled output beat holds its pixel.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// With the output register empty, the whole pipeline can take a beat.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready while the output is empty");

	// An output beat being taken frees a slot that the input can use.
	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while the output is taken");

	// A severity write reads back in the next cycle.
	a_sev_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_SEVERITY
		##1 psel && !pwrite && paddr[2] == REG_SEVERITY
		|-> prdata[12:0] == $past(pwdata[12:0]) && prdata[31:13] == 19'd0)
		else $error("severity read back differs from the value written");

endmodule

bind color_blindness_simulation_pixel_unit cbs_checker u_cbs_checker (.*);

`default_nettype wire

@@ dv/color_blindness_simulation_pixel_unit_tb.sv @@
// Self-checking stream testbench of the color blindness simulation pixel unit.
`timescale 1ns / 100ps

module color_blindness_simulation_pixel_unit_tb;
	import cbs_pkg::*;

	localparam int COEF_FRAC_BITS = 16;
	localparam int LMS_FRAC = 8;
	localparam int PIPE_DEPTH = 6;

	// A pixel as it travels in tdata: red in the lowest byte, blue in the highest.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// Every input starts at a known value; reset is held from time zero.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red_in [7:0], green_in [15:8], blue_in [23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // red_out [7:0], green_out [15:8], blue_out [23:16]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Pixels waiting to be offered, and the simulated pixels still owed by the block.
	pixel_t pixels_to_send[$];
	pixel_t sim_pixels_due[$];

	// Our own copy of the two registers, updated whenever the testbench writes one.
	mode_t       cfg_mode = MODE_NONE;
	logic [12:0] cfg_sev = SEV_ONE;

	int pixels_pushed = 0;
	int pixels_accepted = 0;
	int mismatches = 0;
	int idle_pct = 0;       // chance in percent that a side starts an idle burst
	int send_gap = 0;
	int stall_left = 0;
	int long_hold = 0;      // receiver hold-off requested by the sequence
	bit in_taken = 1'b0;    // an input beat was accepted at the last rising edge

	color_blindness_simulation_pixel_unit #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------------
	// Pixel arithmetic.
	// ---------------------------------------------------------------------------------------

	// A ratio num/den in the signed coefficient format, halves rounded away from zero.
	function automatic longint fixq(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = ((mag << COEF_FRAC_BITS) + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// Drops s fraction bits, rounding to nearest with halves going up (toward +inf).
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// RGB to LMS cone space, row-major: k is three times the row i plus the column j.
	function automatic longint lms_coef(int k);
		case (k)
			0: return fixq(178824, 10000);
			1: return fixq(435161, 10000);
			2: return fixq(411935, 100000);
			3: return fixq(345565, 100000);
			4: return fixq(271554, 10000);
			5: return fixq(386714, 100000);
			6: return fixq(299566, 10000000);
			7: return fixq(184309, 1000000);
			default: return fixq(146709, 100000);
		endcase
	endfunction

	// LMS back to RGB.
	function automatic longint rgb_coef(int k);
		case (k)
			0: return fixq(809, 10000);
			1: return fixq(-1305, 10000);
			2: return fixq(1167, 10000);
			3: return fixq(-102, 10000);
			4: return fixq(540, 10000);
			5: return fixq(-1136, 10000);
			6: return fixq(-4, 10000);
			7: return fixq(-41, 10000);
			default: return fixq(6935, 10000);
		endcase
	endfunction

	// A dichromacy coefficient weighted by the severity in Q12.
	function automatic longint weighted(longint num, longint den, longint sev);
		return round_shift(fixq(num, den) * sev, 12);
	endfunction

	// What the block must return for one pixel under the current register settings.
	function automatic pixel_t simulate_pixel(pixel_t p);
		longint rgb[3];
		longint lms[3];
		longint sim[3];
		longint dm[3][3];
		longint acc;
		longint v;
		longint sev;
		longint one;
		longint keep;
		pixel_t r;
		// A severity above full is treated as full.
		sev = (cfg_sev > SEV_ONE) ? longint'(SEV_ONE) : longint'(cfg_sev);
		one = longint'(1) << COEF_FRAC_BITS;
		keep = one - round_shift(sev << COEF_FRAC_BITS, 12);
		rgb[0] = p.red;
		rgb[1] = p.green;
		rgb[2] = p.blue;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += lms_coef(3 * i + j) * rgb[j];
			lms[i] = round_shift(acc, COEF_FRAC_BITS - LMS_FRAC);
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				dm[i][j] = (i == j) ? one : 0;
		case (cfg_mode)
			MODE_PROT: begin
				dm[0][0] = keep;
				dm[0][1] = weighted(202344, 100000, sev);
				dm[0][2] = weighted(-252581, 100000, sev);
			end
			MODE_DEUT: begin
				dm[1][0] = weighted(494207, 1000000, sev);
				dm[1][1] = keep;
				dm[1][2] = weighted(124827, 100000, sev);
			end
			MODE_TRIT: begin
				dm[2][0] = weighted(-395913, 1000000, sev);
				dm[2][1] = weighted(801109, 1000000, sev);
				dm[2][2] = keep;
			end
			default: ;
		endcase
		// In mode none the LMS values go straight to the back conversion.
		for (int i = 0; i < 3; i++) begin
			if (cfg_mode == MODE_NONE) begin
				sim[i] = lms[i];
			end else begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += dm[i][j] * lms[j];
				sim[i] = round_shift(acc, COEF_FRAC_BITS);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += rgb_coef(3 * i + j) * sim[j];
			v = round_shift(acc, COEF_FRAC_BITS + LMS_FRAC);
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			case (i)
				0: r.red = 8'(v);
				1: r.green = 8'(v);
				default: r.blue = 8'(v);
			endcase
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Stream driver, receiver and monitor.
	// ---------------------------------------------------------------------------------------

	// The sender changes its beat only at falling edges. A beat that was offered stays on
	// the bus until the monitor saw it accepted; then the next one, or an idle burst, follows.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pixels_to_send.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				// This cycle starts an idle burst that send_gap lengthens by a random draw.
				send_gap = $urandom_range(0, 13);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pixels_to_send.pop_front();
			end
		end
	end

	// The receiver stalls in random bursts, and once for a long hold-off that it counts
	// down itself, so that the pipeline fills and the block has to lower s_tready.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Both channels are sampled at the rising edge. An accepted input beat is turned into
	// the pixel the block owes; an accepted output beat is checked against the oldest one.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			in_taken = 1'b0;
		end else begin
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				sim_pixels_due.insert(sim_pixels_due.size(),
					simulate_pixel(pixel_t'(s_tdata)));
				pixels_accepted++;
			end
			if (m_tvalid && m_tready) begin
				got = pixel_t'(m_tdata);
				if (sim_pixels_due.size() == 0) begin
					$error("output beat %h arrived with no pixel outstanding", m_tdata);
					mismatches++;
				end else begin
					want = sim_pixels_due.pop_front();
					if (got.red !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, got.red);
						mismatches++;
					end
					if (got.green !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, got.green);
						mismatches++;
					end
					if (got.blue !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, got.blue);
						mismatches++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Register access.
	// ---------------------------------------------------------------------------------------

	// One transfer: a setup cycle, then an access cycle that completes when pready is high.
	task automatic apb_transfer(input logic idx, input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads both registers back and compares them with our copy.
	task automatic verify_registers();
		logic [31:0] rd;
		apb_transfer(REG_MODE, 1'b0, '0, rd);
		if (rd !== 32'(cfg_mode)) begin
			$error("deficiency_mode: expected %0d, got %0d", cfg_mode, rd);
			mismatches++;
		end
		apb_transfer(REG_SEVERITY, 1'b0, '0, rd);
		if (rd !== 32'(cfg_sev)) begin
			$error("severity: expected %0d, got %0d", cfg_sev, rd);
			mismatches++;
		end
	endtask

	// Writes both registers while the block is idle and reads them back. The dichromacy coefficients
	// follow the registers in the next cycle, so quiet cycles pass before new pixels are queued.
	task automatic program_settings(input mode_t mode, input logic [12:0] sev);
		logic [31:0] rd;
		apb_transfer(REG_MODE, 1'b1, 32'(mode), rd);
		cfg_mode = mode;
		apb_transfer(REG_SEVERITY, 1'b1, 32'(sev), rd);
		cfg_sev = sev;
		verify_registers();
		repeat (3) @(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// Sequence.
	// ---------------------------------------------------------------------------------------

	function automatic logic [7:0] random_level();
		// Pull a component to either rail now and then; saturation lives there.
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_pixel(input pixel_t p);
		pixels_to_send.insert(pixels_to_send.size(), p);
		pixels_pushed++;
	endtask

	// Waits at falling edges, where the rising-edge counters have settled, until every
	// queued pixel went in and came out, then lets the pipeline run empty.
	task automatic wait_drained();
		while (pixels_accepted != pixels_pushed || sim_pixels_due.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	task automatic run_random_phase(input mode_t mode, input logic [12:0] sev, input int n,
			input int idle, input int hold);
		pixel_t p;
		program_settings(mode, sev);
		idle_pct = idle;
		long_hold = hold;
		for (int k = 0; k < n; k++) begin
			p.red = random_level();
			p.green = random_level();
			p.blue = random_level();
			queue_pixel(p);
		end
		wait_drained();
	endtask

	initial begin
		pixel_t p;
		// Reset is held from time zero, then released at a falling edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// After reset the block must come up in mode none at full severity.
		verify_registers();

		// Directed part: black, white, the primaries and a mid gray in every mode,
		// at full severity, with both sides always ready.
		idle_pct = 0;
		for (int m = 0; m < 4; m++) begin
			program_settings(mode_t'(m), SEV_ONE);
			for (int k = 0; k < 6; k++) begin
				case (k)
					0: p = '{blue: 8'h00, green: 8'h00, red: 8'h00};
					1: p = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
					2: p = '{blue: 8'h00, green: 8'h00, red: 8'hFF};
					3: p = '{blue: 8'h00, green: 8'hFF, red: 8'h00};
					4: p = '{blue: 8'hFF, green: 8'h00, red: 8'h00};
					default: p = '{blue: 8'h80, green: 8'h80, red: 8'h7F};
				endcase
				queue_pixel(p);
			end
			wait_drained();
		end

		// Random part. The first phase holds the receiver off for a long stretch while the
		// sender keeps offering beats. Severities cover zero, one, full, the field maximum
		// and values just above full, which must behave as full.
		run_random_phase(MODE_PROT, SEV_ONE, 110, 0, 120);
		run_random_phase(MODE_DEUT, 13'd0, 110, 12, 0);
		run_random_phase(MODE_TRIT, 13'h1FFF, 110, 25, 0);
		run_random_phase(MODE_PROT, 13'($urandom_range(1, 4095)), 110, 12, 0);
		run_random_phase(MODE_DEUT, SEV_ONE, 110, 25, 0);
		run_random_phase(MODE_TRIT, 13'd1, 110, 12, 0);
		run_random_phase(MODE_NONE, 13'd4095, 110, 25, 0);
		run_random_phase(MODE_PROT, 13'd5000, 110, 12, 0);
		run_random_phase(MODE_DEUT, 13'd4097, 110, 25, 0);
		// The closing phase runs with no idling on either side.
		run_random_phase(MODE_TRIT, SEV_ONE, 110, 0, 0);

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run, stalls and gaps included.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
